// ----- src/b30_pkg.sv -----
// Shared types, constants and the character table of the base-30 serial code encoder.
package b30_pkg;

  localparam int unsigned MaxChars = 13;
  localparam int unsigned DigitW   = 5;
  localparam int unsigned CntW     = 4;
  localparam logic [7:0]  SepChar  = 8'h61;

  typedef enum logic [1:0] {
    SEL_DIGIT,
    SEL_SEP,
    SEL_PAD
  } char_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_SEP,
    ST_PAD
  } state_e;

  typedef struct packed {
    logic      load;
    logic      div;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic            div_done;
    logic [CntW-1:0] count;
    logic [CntW-1:0] emit_idx;
  } dp_status_t;

  function automatic logic [7:0] alphabet_char(input logic [DigitW-1:0] digit);
    logic [7:0] ch;
    case (digit)
      5'd0:    ch = 8'h71; // q
      5'd1:    ch = 8'h77; // w
      5'd2:    ch = 8'h65; // e
      5'd3:    ch = 8'h38; // 8
      5'd4:    ch = 8'h73; // s
      5'd5:    ch = 8'h32; // 2
      5'd6:    ch = 8'h64; // d
      5'd7:    ch = 8'h7a; // z
      5'd8:    ch = 8'h78; // x
      5'd9:    ch = 8'h39; // 9
      5'd10:   ch = 8'h63; // c
      5'd11:   ch = 8'h37; // 7
      5'd12:   ch = 8'h70; // p
      5'd13:   ch = 8'h35; // 5
      5'd14:   ch = 8'h6b; // k
      5'd15:   ch = 8'h33; // 3
      5'd16:   ch = 8'h6d; // m
      5'd17:   ch = 8'h6a; // j
      5'd18:   ch = 8'h75; // u
      5'd19:   ch = 8'h66; // f
      5'd20:   ch = 8'h72; // r
      5'd21:   ch = 8'h34; // 4
      5'd22:   ch = 8'h76; // v
      5'd23:   ch = 8'h79; // y
      5'd24:   ch = 8'h74; // t
      5'd25:   ch = 8'h6e; // n
      5'd26:   ch = 8'h36; // 6
      5'd27:   ch = 8'h62; // b
      5'd28:   ch = 8'h67; // g
      5'd29:   ch = 8'h68; // h
      default: ch = 8'h71;
    endcase
    return ch;
  endfunction

endpackage

// ----- src/base30_serial_code_encoder.sv -----
// Top level of the base-30 serial code encoder.
//
// Request channel: drive id_i and pad_entropy_i with start high; the request
// is taken at a rising edge where start is high and busy is low.
// The id is split into base-30 digits by a divide-by-30 unit that takes
// 16 dividend bits per cycle; an id gives n digits, n from 1 to 13.
// Characters then leave one per cycle, most significant
// digit first, followed by the separator 'a' and padding when the code is
// shorter than MIN_LENGTH.
// Each character shows on code_char_o for one cycle with char_valid_o high;
// last_o marks the final character of the code.
// A new request is taken only after the final character of the previous
// code has been emitted; busy stays high until the final character is
// registered.
// Reset clears the controller to idle and drops char_valid_o.
// The receiver cannot stall: every character must be taken when shown.
module base30_serial_code_encoder
  import b30_pkg::*;
#(
  parameter int unsigned MIN_LENGTH = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [62:0] id_i,
  input  logic [39:0] pad_entropy_i,
  output logic [7:0]  code_char_o,
  output logic        last_o,
  output logic        char_valid_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  b30_ctrl #(
    .MIN_LENGTH(MIN_LENGTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .status_i(status),
    .cmd_o   (cmd)
  );

  b30_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .id_i         (id_i),
    .pad_entropy_i(pad_entropy_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .code_char_o  (code_char_o),
    .last_o       (last_o),
    .char_valid_o (char_valid_o)
  );

  a_busy_after_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_gap_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && last_o) |=> !char_valid_o)
    else $error("character follows end of code");

endmodule

// ----- src/b30_dp.sv -----
// Datapath: divide-by-30 digit unit, digit buffer, padding select and output register.
module b30_dp
  import b30_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [62:0]       id_i,
  input  logic [39:0]       pad_entropy_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  output logic [7:0]        code_char_o,
  output logic              last_o,
  output logic              char_valid_o
);

  // floor(v / 30) = (v * Recip) >> 18, exact for v below 30 * 256
  localparam logic [26:0] Recip = 27'd8739;

  logic [63:0]       dvd_q;
  logic [47:0]       qacc_q;
  logic [4:0]        rem_q;
  logic [1:0]        step_q;
  logic [39:0]       pad_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   idx_q;
  logic [2:0]        pad_idx_q;
  logic [DigitW-1:0] dig_mem [MaxChars];

  logic [7:0]        char_q;
  logic              last_q;
  logic              valid_q;

  logic [15:0]       qpair;
  logic [63:0]       quot_next;
  logic [4:0]        rem;
  logic [12:0]       part;
  logic [26:0]       prod;
  logic [7:0]        qbyte;
  logic              step_last;

  logic [CntW-1:0]   rd_idx;
  logic [4:0]        chunk;
  logic [4:0]        pad_digit;

  // Long division by 30, two bytes per cycle from the
  // top of the dividend, remainder carried down
  always_comb begin
    rem   = rem_q;
    part  = '0;
    prod  = '0;
    qbyte = '0;
    qpair = '0;
    for (int k = 1; k >= 0; k--) begin
      part  = {rem, dvd_q[48 + 8*k +: 8]};
      prod  = 27'(part) * Recip;
      qbyte = prod[25:18];
      rem   = 5'(part - 13'(qbyte) * 13'd30);
      qpair[8*k +: 8] = qbyte;
    end
  end

  assign quot_next = {qacc_q, qpair};
  assign step_last = (step_q == 2'd3);

  assign status_o.div_done = step_last &&
                             ((quot_next == '0) || (cnt_q == CntW'(MaxChars - 1)));
  assign status_o.count    = cnt_q;
  assign status_o.emit_idx = idx_q;

  assign rd_idx    = cnt_q - idx_q - CntW'(1);
  assign chunk     = 5'(pad_q >> (6'(pad_idx_q) * 6'd5));
  assign pad_digit = (chunk >= 5'd30) ? chunk - 5'd30 : chunk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q     <= '0;
      qacc_q    <= '0;
      rem_q     <= '0;
      step_q    <= '0;
      pad_q     <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      pad_idx_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.load) begin
        dvd_q     <= {1'b0, id_i};
        qacc_q    <= '0;
        rem_q     <= '0;
        step_q    <= '0;
        pad_q     <= pad_entropy_i;
        cnt_q     <= '0;
        idx_q     <= '0;
        pad_idx_q <= '0;
      end else begin
        if (cmd_i.div) begin
          qacc_q <= quot_next[47:0];
          step_q <= step_q + 2'd1;
          if (step_last) begin
            // restart on the new quotient for the next digit
            dvd_q <= quot_next;
            rem_q <= '0;
            cnt_q <= cnt_q + CntW'(1);
          end else begin
            dvd_q <= {dvd_q[47:0], 16'd0};
            rem_q <= rem;
          end
        end
        if (cmd_i.emit) begin
          idx_q <= idx_q + CntW'(1);
          if (cmd_i.sel == SEL_PAD) begin
            pad_idx_q <= pad_idx_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div && step_last) begin
      dig_mem[cnt_q] <= rem;
    end
    if (cmd_i.emit) begin
      case (cmd_i.sel)
        SEL_DIGIT: char_q <= alphabet_char(dig_mem[rd_idx]);
        SEL_SEP:   char_q <= SepChar;
        SEL_PAD:   char_q <= alphabet_char(pad_digit);
        default:   char_q <= SepChar;
      endcase
      last_q <= cmd_i.last;
    end
  end

  assign code_char_o  = char_q;
  assign last_o       = last_q;
  assign char_valid_o = valid_q;

  a_div_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div |-> (cnt_q < CntW'(MaxChars)))
    else $error("digit step past buffer end");

  a_digit_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.sel == SEL_DIGIT) |-> (idx_q < cnt_q))
    else $error("digit read beyond formed digits");

  a_step_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (step_q == 2'd0))
    else $error("digit unit not aligned after request");

endmodule

// ----- src/b30_ctrl.sv -----
// Controller: sequences load, digit formation and character emission.
module b30_ctrl
  import b30_pkg::*;
#(
  parameter int unsigned MIN_LENGTH = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [4:0] MinLen   = 5'(MIN_LENGTH);
  localparam logic [4:0] TotalLen = (MIN_LENGTH > MaxChars) ? 5'(MaxChars) : 5'(MIN_LENGTH);

  state_e     state_q, state_d;
  logic [4:0] cnt5;
  logic [4:0] idx5;
  logic       pad_needed;
  logic       last_digit;

  assign cnt5       = {1'b0, status_i.count};
  assign idx5       = {1'b0, status_i.emit_idx};
  assign pad_needed = cnt5 < MinLen;
  assign last_digit = (idx5 + 5'd1) == cnt5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_DIGIT;
    busy_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_DIGIT;
        cmd_o.last = last_digit && !pad_needed;
        if (last_digit) begin
          state_d = pad_needed ? ST_SEP : ST_IDLE;
        end
      end
      ST_SEP: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_SEP;
        cmd_o.last = (idx5 + 5'd1) >= TotalLen;
        state_d    = cmd_o.last ? ST_IDLE : ST_PAD;
      end
      ST_PAD: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_PAD;
        cmd_o.last = (idx5 + 5'd1) >= TotalLen;
        if (cmd_o.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the base-30 serial code encoder.
`timescale 1ns / 100ps

module tb_top
  import b30_pkg::*;
();

  localparam int unsigned MinLength   = 10;
  localparam int unsigned NumRandom   = 150;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned MaxReports  = 10;
  localparam logic [239:0] CodeAlphabet = "qwe8s2dzx9c7p5k3mjufr4vytn6bgh";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } code_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [62:0] id_i;
  logic [39:0] pad_entropy_i;
  logic [7:0]  code_char_o;
  logic        last_o;
  logic        char_valid_o;

  code_char_t  code_q[$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned chars_seen;
  bit          no_idle;

  base30_serial_code_encoder #(
    .MIN_LENGTH(MinLength)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .id_i         (id_i),
    .pad_entropy_i(pad_entropy_i),
    .code_char_o  (code_char_o),
    .last_o       (last_o),
    .char_valid_o (char_valid_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] digit_char(input logic [4:0] digit);
    int idx;
    idx = 29 - int'(digit);
    return CodeAlphabet[8*idx +: 8];
  endfunction

  function automatic logic [63:0] pow30(input int k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd30;
    return p;
  endfunction

  // Work out the characters of one code and queue them for the checker.
  function automatic void predict_code(input logic [62:0] id, input logic [39:0] pad);
    logic [62:0] rest;
    logic [4:0]  digits[13];
    logic [7:0]  chars[13];
    logic [4:0]  chunk;
    int          n;
    int          len;
    int          total;
    int          k;
    code_char_t  c;
    rest = id;
    n = 0;
    do begin
      digits[n] = 5'(rest % 63'd30);
      n++;
      rest = rest / 63'd30;
    end while (rest != 0 && n < 13);
    len = 0;
    for (k = n - 1; k >= 0; k--) begin
      chars[len] = digit_char(digits[k]);
      len++;
    end
    if (n < MinLength) begin
      total = (MinLength > 13) ? 13 : MinLength;
      chars[len] = SepChar;
      len++;
      for (k = 0; len < total; k++) begin
        chunk = pad[5*(k%8) +: 5];
        chars[len] = digit_char(5'(chunk % 5'd30));
        len++;
      end
    end
    for (k = 0; k < len; k++) begin
      c.ch   = chars[k];
      c.last = (k == len - 1);
      code_q.push_back(c);
    end
  endfunction

  function automatic void report_mismatch(input code_char_t want, input bit have_want);
    mismatches++;
    if (mismatches <= MaxReports) begin
      if (have_want)
        $display("%0t: char mismatch: expected %h last %b, got %h last %b",
                 $realtime, want.ch, want.last, code_char_o, last_o);
      else
        $display("%0t: unexpected char %h last %b", $realtime, code_char_o, last_o);
    end
  endfunction

  always @(posedge clk_i) begin : check_chars
    code_char_t want;
    if (rst_ni && char_valid_o) begin
      chars_seen++;
      if (code_q.size() == 0) begin
        want = '0;
        report_mismatch(want, 1'b0);
      end else begin
        want = code_q.pop_front();
        if (code_char_o !== want.ch || last_o !== want.last) report_mismatch(want, 1'b1);
      end
    end
  end

  // Hold start through back-to-back requests; drop it only for a gap.
  task automatic send_request(input logic [62:0] id, input logic [39:0] pad);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    id_i          <= id;
    pad_entropy_i <= pad;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_code(id, pad);
    requests_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (code_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [39:0] rand_pad();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_zero_id();
    send_request(63'd0, 40'd0);
    send_request(63'd0, {40{1'b1}});
    // every chunk at 30, which wraps to the first alphabet entry
    send_request(63'd0, {8{5'd30}});
    send_request(63'd0, rand_pad());
  endtask

  task automatic test_pad_chunks();
    send_request(63'd1, {5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0});
    send_request(63'd29, {5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24});
    send_request(63'd30, {8{5'd31}});
  endtask

  task automatic test_digit_boundaries();
    send_request(63'(pow30(8) - 1), rand_pad());
    send_request(63'(pow30(8)), rand_pad());
    send_request(63'(pow30(9) - 1), rand_pad());
    send_request(63'(pow30(9)), rand_pad());
    send_request(63'(pow30(12) - 1), rand_pad());
    send_request(63'(pow30(12)), rand_pad());
    send_request({63{1'b1}}, {40{1'b1}});
    send_request({1'b1, 62'd0}, 40'd0);
    send_request(63'h2AAA_AAAA_AAAA_AAAA, 40'h55_5555_5555);
    send_request(63'h5555_5555_5555_5555, 40'hAA_AAAA_AAAA);
  endtask

  task automatic test_random();
    logic [63:0] raw;
    logic [62:0] id;
    int unsigned i;
    for (i = 0; i < NumRandom; i++) begin
      if (i % 25 == 0) no_idle = ($urandom_range(0, 2) == 0);
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
        0: id = raw[62:0];
        1: id = 63'(raw >> $urandom_range(1, 64));
        2: id = 63'(pow30($urandom_range(0, 12)) + $urandom_range(0, 2) - 1);
        default: id = 63'($urandom_range(0, 999));
      endcase
      send_request(id, rand_pad());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    id_i          = '0;
    pad_entropy_i = '0;
    mismatches    = 0;
    requests_sent = 0;
    chars_seen    = 0;
    no_idle       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_id();
    test_pad_chunks();
    test_digit_boundaries();
    test_random();
    wait_idle();

    $display("Encoded %0d ids into %0d characters, zero, padded, unpadded and 13-digit codes",
             requests_sent, chars_seen);
    $display("Mismatches: %0d, characters still expected: %0d", mismatches, code_q.size());
    if (mismatches == 0 && code_q.size() == 0) begin
      $display("** base30_serial_code_encoder: PASSED **");
    end else begin
      $display("** base30_serial_code_encoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout after %0d requests", requests_sent);
    $display("** base30_serial_code_encoder: FAILED **");
    $finish;
  end

endmodule

// ----- base30_serial_code_encoder.f -----
src/b30_pkg.sv
src/b30_dp.sv
src/b30_ctrl.sv
src/base30_serial_code_encoder.sv
dv/tb_top.sv
